@@ rtl/ulsid_pkg.sv @@
// ----------------------------------------------------------------------------
// ulsid_pkg
// Shared types and codes for the unsorted list search/insert/delete block.
// ----------------------------------------------------------------------------
package ulsid_pkg;

	localparam int CMD_W    = 2;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int POS_W    = 4;
	localparam int LCNT_W   = 5;

	localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd0;
	localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
	localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

	// per-cell control, one bundle shared by the whole row
	typedef struct packed {
		logic compare; // latch match flag against incoming value
		logic shift;   // delete: cells at or after first match take neighbor
	} cell_ctrl_t;

endpackage

@@ rtl/ulsid_cell.sv @@
// ----------------------------------------------------------------------------
// ulsid_cell
// One list slot: holds an entry, flags a match, passes the match chain on and
// takes its right neighbor's entry on delete.
// ----------------------------------------------------------------------------
module ulsid_cell
	import ulsid_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  cell_ctrl_t         ctrl,
	input  logic               live,
	input  logic               load,
	input  logic [VALUE_W-1:0] value,
	input  logic [VALUE_W-1:0] next_entry,
	input  logic               chain_in,
	output logic               chain_out,
	output logic               first,
	output logic [VALUE_W-1:0] entry
);

	logic [VALUE_W-1:0] entry_q;
	logic               match_q;

	assign chain_out = chain_in | match_q;
	assign first     = match_q & ~chain_in;
	assign entry     = entry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (ctrl.compare) begin
			match_q <= live && (entry_q == value);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			entry_q <= value;
		end else if (ctrl.shift && chain_out) begin
			entry_q <= next_entry;
		end
	end

endmodule

@@ rtl/unsorted_list_search_insert_delete.sv @@
// ----------------------------------------------------------------------------
// unsorted_list_search_insert_delete
// Unordered list of signed 32-bit values with search, append and compacting
// delete, built as a row of compare cells.
// ----------------------------------------------------------------------------
// Every cell compares its entry with the value when the item is accepted and
// registers its match flag; in the resolve state the first-match chain runs
// across the row of cells, the list is updated and the result is registered.
// That chain through all CAPACITY cells is the longest path. A finished result
// waits in the output register while the next item is accepted; the block only
// holds in the resolve cycle if the previous result has not yet been taken.
// Entries at or above the live count never match, so no clearing is needed.
module unsorted_list_search_insert_delete
	import ulsid_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // command[1:0], value[33:2], zero fill
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata   // status[1:0], position[5:2], live_count[10:6], zero fill
);

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

	typedef enum logic [1:0] {
		S_IDLE    = 2'b01,
		S_RESOLVE = 2'b10
	} state_t;

	state_t              state_q;
	logic [CMD_W-1:0]    cmd_q;
	logic [VALUE_W-1:0]  value_q;
	logic [CNT_W-1:0]    count_q;
	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [POS_W-1:0]    pos_q;
	logic [LCNT_W-1:0]   lcnt_q;

	logic               accept;
	logic               commit;
	logic [VALUE_W-1:0] cell_value;
	cell_ctrl_t         ctrl;

	logic [CAPACITY:0]   chain;
	logic [CAPACITY-1:0] first;
	logic [CAPACITY-1:0] live;
	logic [CAPACITY-1:0] load;
	logic [VALUE_W-1:0]  entry [CAPACITY];

	logic                found;
	logic                full;
	logic [IDX_W-1:0]    first_idx;
	logic [CNT_W-1:0]    count_next;
	logic [STATUS_W-1:0] status_next;
	logic [IDX_W-1:0]    pos_next;
	logic [IDX_W+POS_W-1:0]  pos_wide;
	logic [CNT_W+LCNT_W-1:0] cnt_wide;

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign commit   = (state_q == S_RESOLVE) && (!out_valid_q || m_tready);

	// compare against the incoming value at accept, write the held one after
	assign cell_value   = accept ? s_tdata[33:2] : value_q;
	assign ctrl.compare = accept;
	assign ctrl.shift   = commit && (cmd_q == CMD_DELETE) && found;

	assign full = (count_q >= CAP_CNT);

	assign chain[0] = 1'b0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		assign live[i] = (CNT_W'(i) < count_q);
		assign load[i] = commit && (cmd_q == CMD_APPEND) && !full
			&& (count_q == CNT_W'(i));

		ulsid_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.live       (live[i]),
			.load       (load[i]),
			.value      (cell_value),
			.next_entry (entry[(i + 1 < CAPACITY) ? i + 1 : i]),
			.chain_in   (chain[i]),
			.chain_out  (chain[i+1]),
			.first      (first[i]),
			.entry      (entry[i])
		);
	end

	assign found = chain[CAPACITY];

	// first is one-hot or empty, so an OR of indexes gives the position
	always_comb begin
		first_idx = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			first_idx = first_idx | (first[i] ? IDX_W'(i) : IDX_W'(0));
		end
	end

	always_comb begin
		status_next = ST_NOT_FOUND;
		pos_next    = '0;
		count_next  = count_q;
		case (cmd_q)
			CMD_SEARCH: begin
				if (found) begin
					status_next = ST_OK;
					pos_next    = first_idx;
				end
			end
			CMD_APPEND: begin
				if (full) begin
					status_next = ST_FULL;
				end else begin
					status_next = ST_OK;
					pos_next    = count_q[IDX_W-1:0];
					count_next  = count_q + CNT_W'(1);
				end
			end
			CMD_DELETE: begin
				if (found) begin
					status_next = ST_OK;
					pos_next    = first_idx;
					count_next  = count_q - CNT_W'(1);
				end
			end
			default: begin
				status_next = ST_NOT_FOUND;
			end
		endcase
	end

	assign pos_wide = {{POS_W{1'b0}}, pos_next};
	assign cnt_wide = {{LCNT_W{1'b0}}, count_next};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_RESOLVE;
					end
				end
				S_RESOLVE: begin
					if (commit) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (commit) begin
				count_q     <= count_next;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= s_tdata[1:0];
			value_q <= s_tdata[33:2];
		end
		if (commit) begin
			status_q <= status_next;
			pos_q    <= pos_wide[POS_W-1:0];
			lcnt_q   <= cnt_wide[LCNT_W-1:0];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'd0, lcnt_q, pos_q, status_q};

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the unsorted list block. A directed table covers the
// empty list, every command, the value extremes, filling to capacity, an append
// when full, duplicates and deletes at the front, middle and end. Random
// command mixes then walk the live count up and down. Every result is checked
// field by field against the table's expected fields or a shadow copy of the
// list, with random idle gaps on both streams.
// ----------------------------------------------------------------------------
module tb_top;
	import ulsid_pkg::*;

	localparam int CAPACITY    = 16;
	localparam int DIR_ROWS    = 26;
	localparam int RAND_ITEMS  = 1424;
	localparam int SEG_LEN     = 40;
	localparam int HOLD_CYCLES = 60;
	localparam int CYCLE_LIMIT = 400000;
	localparam int IN_W        = 40;

	// code 3 carries no meaning; the block must answer not found
	localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [POS_W-1:0]    position;
		logic [LCNT_W-1:0]   live_count;
	} list_result_t;

	typedef struct packed {
		logic [CMD_W-1:0]    command;
		logic [VALUE_W-1:0]  value;
		logic                typed;
		logic [STATUS_W-1:0] status;
		logic [POS_W-1:0]    position;
		logic [LCNT_W-1:0]   live_count;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;   // command[1:0], value[33:2], zero fill
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;   // status[1:0], position[5:2], live_count[10:6], zero fill

	logic [VALUE_W-1:0] shadow_entries [CAPACITY];
	int                 shadow_count;
	list_result_t       pending_results [$];
	dir_row_t           dir_table [DIR_ROWS];
	int unsigned        mismatches;
	int unsigned        cycle_cnt;
	bit                 burst_mode;
	bit                 hold_request;
	int                 append_weight;
	int                 delete_weight;

	unsorted_list_search_insert_delete #(
		.CAPACITY(CAPACITY)
	) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	task automatic report_mismatch(string msg);
		$display("MISMATCH @%0t: %s", $time, msg);
		mismatches++;
	endtask

	// Applies one command to the shadow list and returns the result it gives.
	function automatic list_result_t apply_command(logic [CMD_W-1:0] cmd,
			logic [VALUE_W-1:0] val);
		list_result_t r;
		int hit;
		r.status   = ST_NOT_FOUND;
		r.position = '0;
		hit = -1;
		for (int i = shadow_count - 1; i >= 0; i--)
			if (shadow_entries[i] == val)
				hit = i;
		case (cmd)
			CMD_SEARCH: if (hit >= 0) begin
				r.status   = ST_OK;
				r.position = POS_W'(hit);
			end
			CMD_APPEND: if (shadow_count >= CAPACITY) begin
				r.status = ST_FULL;
			end else begin
				shadow_entries[shadow_count] = val;
				r.position = POS_W'(shadow_count);
				r.status   = ST_OK;
				shadow_count++;
			end
			CMD_DELETE: if (hit >= 0) begin
				for (int i = hit; i < shadow_count - 1; i++)
					shadow_entries[i] = shadow_entries[i + 1];
				shadow_count--;
				r.status   = ST_OK;
				r.position = POS_W'(hit);
			end
			default: ;
		endcase
		r.live_count = LCNT_W'(shadow_count);
		return r;
	endfunction

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		else if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(5, 30);
	endfunction

	function automatic logic [VALUE_W-1:0] pool_value();
		case ($urandom_range(0, 7))
			0: return 32'h0000_0000;
			1: return 32'h0000_0001;
			2: return 32'hFFFF_FFFF;
			3: return 32'h8000_0000;
			4: return 32'h7FFF_FFFF;
			5: return 32'h0000_0005;
			6: return 32'h0000_0006;
			default: return 32'hDEAD_0007;
		endcase
	endfunction

	// Lookups mostly hit a live entry so search and delete find something.
	function automatic logic [VALUE_W-1:0] pick_operand(bit lookup);
		int roll;
		roll = $urandom_range(0, 99);
		if (lookup && shadow_count > 0 && roll < 60)
			return shadow_entries[$urandom_range(0, shadow_count - 1)];
		else if (roll < 80)
			return pool_value();
		return $urandom;
	endfunction

	function automatic logic [CMD_W-1:0] pick_command();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 5)
			return CMD_NONE;
		else if (roll < 5 + append_weight)
			return CMD_APPEND;
		else if (roll < 5 + append_weight + delete_weight)
			return CMD_DELETE;
		return CMD_SEARCH;
	endfunction

	// Entered and left at a falling edge; valid stays high into the next item
	// unless a gap is drawn.
	task automatic send_item(logic [CMD_W-1:0] cmd, logic [VALUE_W-1:0] val,
			bit typed, list_result_t typed_res);
		int gap;
		list_result_t predicted;
		gap = burst_mode ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid = 1'b0;
			s_tdata  = IN_W'({$urandom, $urandom});
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = {{(IN_W - CMD_W - VALUE_W){1'b0}}, val, cmd};
		do @(posedge clk); while (!s_tready);
		predicted = apply_command(cmd, val);
		pending_results.push_back(typed ? typed_res : predicted);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_tvalid = 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	// stimulus
	initial begin
		list_result_t typed_res;
		logic [CMD_W-1:0] cmd;
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		mismatches    = 0;
		shadow_count  = 0;
		burst_mode    = 1'b0;
		hold_request  = 1'b0;
		append_weight = 35;
		delete_weight = 35;
		for (int i = 0; i < CAPACITY; i++)
			shadow_entries[i] = '0;

		dir_table = '{
			'{CMD_SEARCH, 32'h0000_0000, 1'b1, ST_NOT_FOUND, 4'd0,  5'd0},
			'{CMD_DELETE, 32'hFFFF_FFFF, 1'b1, ST_NOT_FOUND, 4'd0,  5'd0},
			'{CMD_NONE,   32'h0000_1234, 1'b1, ST_NOT_FOUND, 4'd0,  5'd0},
			'{CMD_APPEND, 32'h8000_0000, 1'b1, ST_OK,        4'd0,  5'd1},
			'{CMD_APPEND, 32'h7FFF_FFFF, 1'b1, ST_OK,        4'd1,  5'd2},
			'{CMD_APPEND, 32'h0000_0000, 1'b1, ST_OK,        4'd2,  5'd3},
			'{CMD_APPEND, 32'hFFFF_FFFF, 1'b1, ST_OK,        4'd3,  5'd4},
			'{CMD_APPEND, 32'h0000_0001, 1'b1, ST_OK,        4'd4,  5'd5},
			'{CMD_APPEND, 32'h5555_5555, 1'b1, ST_OK,        4'd5,  5'd6},
			'{CMD_APPEND, 32'hAAAA_AAAA, 1'b1, ST_OK,        4'd6,  5'd7},
			'{CMD_APPEND, 32'h0000_002A, 1'b1, ST_OK,        4'd7,  5'd8},
			'{CMD_APPEND, 32'h0000_002A, 1'b1, ST_OK,        4'd8,  5'd9},
			'{CMD_APPEND, 32'h0000_0007, 1'b1, ST_OK,        4'd9,  5'd10},
			'{CMD_APPEND, 32'h0000_0008, 1'b1, ST_OK,        4'd10, 5'd11},
			'{CMD_APPEND, 32'h0000_FFFF, 1'b1, ST_OK,        4'd11, 5'd12},
			'{CMD_APPEND, 32'hFFFF_0000, 1'b1, ST_OK,        4'd12, 5'd13},
			'{CMD_APPEND, 32'h1234_5678, 1'b1, ST_OK,        4'd13, 5'd14},
			'{CMD_APPEND, 32'h0000_0009, 1'b1, ST_OK,        4'd14, 5'd15},
			'{CMD_APPEND, 32'h7FFF_FFFF, 1'b1, ST_OK,        4'd15, 5'd16},
			'{CMD_APPEND, 32'h0000_0001, 1'b1, ST_FULL,      4'd0,  5'd16},
			'{CMD_SEARCH, 32'h0000_002A, 1'b0, ST_OK,        4'd0,  5'd0},
			'{CMD_DELETE, 32'h8000_0000, 1'b0, ST_OK,        4'd0,  5'd0},
			'{CMD_DELETE, 32'h7FFF_FFFF, 1'b0, ST_OK,        4'd0,  5'd0},
			'{CMD_DELETE, 32'h7FFF_FFFF, 1'b0, ST_OK,        4'd0,  5'd0},
			'{CMD_SEARCH, 32'h7FFF_FFFF, 1'b0, ST_OK,        4'd0,  5'd0},
			'{CMD_DELETE, 32'h0000_002A, 1'b0, ST_OK,        4'd0,  5'd0}
		};

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_table[i]) begin
			typed_res.status     = dir_table[i].status;
			typed_res.position   = dir_table[i].position;
			typed_res.live_count = dir_table[i].live_count;
			send_item(dir_table[i].command, dir_table[i].value, dir_table[i].typed,
				typed_res);
		end

		for (int seg = 0; seg * SEG_LEN < RAND_ITEMS; seg++) begin
			// segments lean toward filling, emptying or neither
			case ($urandom_range(0, 2))
				0: begin
					append_weight = 55;
					delete_weight = 15;
				end
				1: begin
					append_weight = 15;
					delete_weight = 55;
				end
				default: begin
					append_weight = 35;
					delete_weight = 35;
				end
			endcase
			burst_mode = ($urandom_range(0, 4) == 0);
			if (seg == 4) begin
				// sink holds off while the source keeps pushing
				hold_request = 1'b1;
				burst_mode   = 1'b1;
			end
			if (seg == 12)
				wait_drained();
			for (int k = 0; k < SEG_LEN; k++) begin
				cmd = pick_command();
				send_item(cmd, pick_operand(cmd != CMD_APPEND), 1'b0, '0);
			end
		end

		wait_drained();
		repeat (8) @(negedge clk);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// result sink
	initial begin
		int stall_left;
		int roll;
		m_tready   = 1'b0;
		stall_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				stall_left   = HOLD_CYCLES;
			end
			if (stall_left > 0) begin
				m_tready = 1'b0;
				stall_left--;
			end else if (burst_mode) begin
				m_tready = 1'b1;
			end else begin
				roll = $urandom_range(0, 99);
				if (roll < 4) begin
					stall_left = $urandom_range(5, 30);
					m_tready   = 1'b0;
				end else begin
					m_tready = (roll >= 25);
				end
			end
		end
	end

	always @(posedge clk) begin : result_check
		list_result_t got;
		list_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.status     = m_tdata[1:0];
			got.position   = m_tdata[5:2];
			got.live_count = m_tdata[10:6];
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("result %h with no item pending", m_tdata));
			end else begin
				want = pending_results.pop_front();
				if (got.status !== want.status)
					report_mismatch($sformatf("status %0d, want %0d",
						got.status, want.status));
				if (got.position !== want.position)
					report_mismatch($sformatf("position %0d, want %0d",
						got.position, want.position));
				if (got.live_count !== want.live_count)
					report_mismatch($sformatf("live_count %0d, want %0d",
						got.live_count, want.live_count));
			end
		end
	end

	initial begin
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("TIMEOUT after %0d cycles, %0d items pending", cycle_cnt,
			pending_results.size());
		$display("Some tests failed");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/ulsid_pkg.sv
rtl/ulsid_cell.sv
rtl/unsorted_list_search_insert_delete.sv
tb/tb_top.sv
